// ----- hdl/assert_macros.svh -----
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain property checked at every rising clock edge
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- hdl/tnr_pkg.sv -----
package tnr_pkg;

    localparam int TABLE_SLOTS = 4;
    localparam int ENTRY_W     = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int MASK_W      = 2 * TABLE_SLOTS;
    localparam int MIDX_W      = 3;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // telnet command bytes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;

    // input operations
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_START = 1'b1;

    // config index: low bit picks the support register of an entry
    localparam logic REG_SEL_SUPPORT = 1'b1;

    // support bits
    localparam int SUP_LOCAL  = 0;
    localparam int SUP_REMOTE = 1;

    // per-option flag bits
    localparam int FLAG_LEN  = 0;
    localparam int FLAG_LNEG = 1;
    localparam int FLAG_REN  = 2;
    localparam int FLAG_RNEG = 3;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_SEND    = 3'd1,
        KIND_EVENT   = 3'd2,
        KIND_SUB     = 3'd3,
        KIND_SUB_END = 3'd4,
        KIND_CMD     = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        VERB_WILL = 2'd0,
        VERB_WONT = 2'd1,
        VERB_DO   = 2'd2,
        VERB_DONT = 2'd3
    } verb_t;

    typedef enum logic [2:0] {
        EV_LOCAL_EN   = 3'd0,
        EV_LOCAL_DIS  = 3'd1,
        EV_LOCAL_REJ  = 3'd2,
        EV_REMOTE_EN  = 3'd3,
        EV_REMOTE_DIS = 3'd4,
        EV_REMOTE_REJ = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_IAC    = 3'd1,
        PH_VERB   = 3'd2,
        PH_SBOPT  = 3'd3,
        PH_SUB    = 3'd4,
        PH_SUBIAC = 3'd5
    } phase_t;

    typedef logic [TABLE_SLOTS-1:0][7:0] code_tbl_t;
    typedef logic [TABLE_SLOTS-1:0][1:0] sup_tbl_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_value;
        verb_t      verb;
        logic [7:0] option_code;
        event_t     event_code;
    } res_t;

    // one queued job: either up to two ready words or a start sweep mask
    typedef struct packed {
        logic              start;
        logic [MASK_W-1:0] mask;
        logic              two;
        res_t              r0;
        res_t              r1;
    } desc_t;

    function automatic res_t mk_res(kind_t k, logic [7:0] b, verb_t v,
                                    logic [7:0] opt, event_t ev);
        res_t r;
        r.kind        = k;
        r.byte_value  = b;
        r.verb        = v;
        r.option_code = opt;
        r.event_code  = ev;
        return r;
    endfunction

endpackage

// ----- hdl/tnr_queue.sv -----
module tnr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tnr_pkg::desc_t push_desc,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output tnr_pkg::desc_t head
);
    import tnr_pkg::*;

    desc_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- hdl/tnr_front.sv -----
module tnr_front #(
    parameter int NUM_OPTIONS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               op,
    input  logic [7:0]         rx_byte,
    input  tnr_pkg::code_tbl_t codes,
    input  tnr_pkg::sup_tbl_t  sups,
    output logic               push,
    output tnr_pkg::desc_t     push_desc
);
    import tnr_pkg::*;

    phase_t       phase_reg, phase_next;
    verb_t        held_verb_reg, held_verb_next;
    logic [7:0]   sub_option_reg, sub_option_next;
    logic         sub_known_reg, sub_known_next;
    logic [3:0]   flags_reg [TABLE_SLOTS];
    logic [3:0]   flags_next [TABLE_SLOTS];

    desc_t              desc;
    logic [1:0]         nres;
    logic [ENTRY_W:0]   hit;
    logic [ENTRY_W-1:0] ent;
    logic [3:0]         f;
    logic [1:0]         sup;
    logic [7:0]         verb_diff;

    // lowest matching entry wins; {found, index}
    function automatic logic [ENTRY_W:0] lookup(code_tbl_t c, logic [7:0] b);
        logic [ENTRY_W:0] r;
        r = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (i < NUM_OPTIONS && c[i] == b)
            begin
                r = {1'b1, ENTRY_W'(i)};
            end
        end
        return r;
    endfunction

    function automatic desc_t put(desc_t d, logic [1:0] n, res_t r);
        desc_t o;
        o = d;
        if (n == 2'd0)
        begin
            o.r0 = r;
        end
        else
        begin
            o.r1 = r;
        end
        return o;
    endfunction

    always_comb
    begin
        phase_next      = phase_reg;
        held_verb_next  = held_verb_reg;
        sub_option_next = sub_option_reg;
        sub_known_next  = sub_known_reg;
        flags_next      = flags_reg;
        desc            = '0;
        nres            = 2'd0;
        hit             = lookup(codes, rx_byte);
        ent             = hit[ENTRY_W-1:0];
        f               = flags_reg[ent];
        sup             = sups[ent];
        verb_diff       = rx_byte - B_WILL;

        if (accept)
        begin
            if (op == OP_START)
            begin
                desc.start = 1'b1;
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (i < NUM_OPTIONS)
                    begin
                        desc.mask[2*i]   = sups[i][SUP_LOCAL];
                        desc.mask[2*i+1] = sups[i][SUP_REMOTE];
                        if (sups[i][SUP_LOCAL])
                        begin
                            flags_next[i][FLAG_LNEG] = 1'b1;
                        end
                        if (sups[i][SUP_REMOTE])
                        begin
                            flags_next[i][FLAG_RNEG] = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (rx_byte == B_IAC)
                        begin
                            phase_next = PH_IAC;
                        end
                        else
                        begin
                            desc = put(desc, nres, mk_res(KIND_DATA, rx_byte, VERB_WILL,
                                                          8'h00, EV_LOCAL_EN));
                            nres = nres + 2'd1;
                        end
                    end
                    PH_IAC:
                    begin
                        if (rx_byte == B_IAC)
                        begin
                            desc = put(desc, nres, mk_res(KIND_DATA, B_IAC, VERB_WILL,
                                                          8'h00, EV_LOCAL_EN));
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else if (rx_byte >= B_WILL && rx_byte <= B_DONT)
                        begin
                            held_verb_next = verb_t'(verb_diff[1:0]);
                            phase_next     = PH_VERB;
                        end
                        else if (rx_byte == B_SB)
                        begin
                            phase_next = PH_SBOPT;
                        end
                        else
                        begin
                            desc = put(desc, nres, mk_res(KIND_CMD, rx_byte, VERB_WILL,
                                                          8'h00, EV_LOCAL_EN));
                            nres = nres + 2'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_VERB:
                    begin
                        phase_next = PH_IDLE;
                        if (!hit[ENTRY_W])
                        begin
                            // unknown option: refuse requests, ignore refusals
                            if (held_verb_reg == VERB_WILL)
                            begin
                                desc = put(desc, nres, mk_res(KIND_SEND, 8'h00, VERB_DONT,
                                                              rx_byte, EV_LOCAL_EN));
                                nres = nres + 2'd1;
                            end
                            else if (held_verb_reg == VERB_DO)
                            begin
                                desc = put(desc, nres, mk_res(KIND_SEND, 8'h00, VERB_WONT,
                                                              rx_byte, EV_LOCAL_EN));
                                nres = nres + 2'd1;
                            end
                        end
                        else
                        begin
                            unique case (held_verb_reg)
                                VERB_WILL:
                                begin
                                    if (sup[SUP_REMOTE])
                                    begin
                                        if (!f[FLAG_REN])
                                        begin
                                            f[FLAG_REN] = 1'b1;
                                            if (!f[FLAG_RNEG])
                                            begin
                                                desc = put(desc, nres,
                                                    mk_res(KIND_SEND, 8'h00, VERB_DO,
                                                           rx_byte, EV_LOCAL_EN));
                                                nres = nres + 2'd1;
                                            end
                                            desc = put(desc, nres,
                                                mk_res(KIND_EVENT, 8'h00, VERB_WILL,
                                                       rx_byte, EV_REMOTE_EN));
                                            nres = nres + 2'd1;
                                        end
                                    end
                                    else
                                    begin
                                        desc = put(desc, nres,
                                            mk_res(KIND_SEND, 8'h00, VERB_DONT,
                                                   rx_byte, EV_LOCAL_EN));
                                        nres = nres + 2'd1;
                                    end
                                end
                                VERB_DO:
                                begin
                                    if (sup[SUP_LOCAL])
                                    begin
                                        if (!f[FLAG_LEN])
                                        begin
                                            f[FLAG_LEN] = 1'b1;
                                            if (!f[FLAG_LNEG])
                                            begin
                                                desc = put(desc, nres,
                                                    mk_res(KIND_SEND, 8'h00, VERB_WILL,
                                                           rx_byte, EV_LOCAL_EN));
                                                nres = nres + 2'd1;
                                            end
                                            desc = put(desc, nres,
                                                mk_res(KIND_EVENT, 8'h00, VERB_WILL,
                                                       rx_byte, EV_LOCAL_EN));
                                            nres = nres + 2'd1;
                                        end
                                    end
                                    else
                                    begin
                                        desc = put(desc, nres,
                                            mk_res(KIND_SEND, 8'h00, VERB_WONT,
                                                   rx_byte, EV_LOCAL_EN));
                                        nres = nres + 2'd1;
                                    end
                                end
                                VERB_WONT:
                                begin
                                    if (sup[SUP_REMOTE])
                                    begin
                                        if (f[FLAG_REN])
                                        begin
                                            f[FLAG_REN] = 1'b0;
                                            desc = put(desc, nres,
                                                mk_res(KIND_EVENT, 8'h00, VERB_WILL,
                                                       rx_byte, EV_REMOTE_DIS));
                                            nres = nres + 2'd1;
                                        end
                                        if (f[FLAG_RNEG])
                                        begin
                                            f[FLAG_RNEG] = 1'b0;
                                            desc = put(desc, nres,
                                                mk_res(KIND_EVENT, 8'h00, VERB_WILL,
                                                       rx_byte, EV_REMOTE_REJ));
                                            nres = nres + 2'd1;
                                        end
                                    end
                                end
                                VERB_DONT:
                                begin
                                    if (sup[SUP_LOCAL])
                                    begin
                                        if (f[FLAG_LEN])
                                        begin
                                            f[FLAG_LEN] = 1'b0;
                                            desc = put(desc, nres,
                                                mk_res(KIND_EVENT, 8'h00, VERB_WILL,
                                                       rx_byte, EV_LOCAL_DIS));
                                            nres = nres + 2'd1;
                                        end
                                        if (f[FLAG_LNEG])
                                        begin
                                            f[FLAG_LNEG] = 1'b0;
                                            desc = put(desc, nres,
                                                mk_res(KIND_EVENT, 8'h00, VERB_WILL,
                                                       rx_byte, EV_LOCAL_REJ));
                                            nres = nres + 2'd1;
                                        end
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                            flags_next[ent] = f;
                        end
                    end
                    PH_SBOPT:
                    begin
                        // byte after SB is the option, whatever its value
                        sub_option_next = rx_byte;
                        sub_known_next  = hit[ENTRY_W];
                        phase_next      = PH_SUB;
                    end
                    PH_SUB:
                    begin
                        if (rx_byte == B_IAC)
                        begin
                            phase_next = PH_SUBIAC;
                        end
                        else if (sub_known_reg)
                        begin
                            desc = put(desc, nres, mk_res(KIND_SUB, rx_byte, VERB_WILL,
                                                          sub_option_reg, EV_LOCAL_EN));
                            nres = nres + 2'd1;
                        end
                    end
                    PH_SUBIAC:
                    begin
                        if (rx_byte == B_SE)
                        begin
                            if (sub_known_reg)
                            begin
                                desc = put(desc, nres, mk_res(KIND_SUB_END, 8'h00, VERB_WILL,
                                                              sub_option_reg, EV_LOCAL_EN));
                                nres = nres + 2'd1;
                            end
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            // escaped 255, plus the stray byte when it is not IAC
                            if (sub_known_reg)
                            begin
                                desc = put(desc, nres, mk_res(KIND_SUB, B_IAC, VERB_WILL,
                                                              sub_option_reg, EV_LOCAL_EN));
                                nres = nres + 2'd1;
                                if (rx_byte != B_IAC)
                                begin
                                    desc = put(desc, nres, mk_res(KIND_SUB, rx_byte,
                                                                  VERB_WILL, sub_option_reg,
                                                                  EV_LOCAL_EN));
                                    nres = nres + 2'd1;
                                end
                            end
                            phase_next = PH_SUB;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        desc.two  = (nres == 2'd2);
        push      = accept && (desc.start ? (desc.mask != '0) : (nres != 2'd0));
        push_desc = desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            held_verb_reg  <= VERB_WILL;
            sub_option_reg <= '0;
            sub_known_reg  <= 1'b0;
            flags_reg      <= '{default: '0};
        end
        else
        begin
            phase_reg      <= phase_next;
            held_verb_reg  <= held_verb_next;
            sub_option_reg <= sub_option_next;
            sub_known_reg  <= sub_known_next;
            flags_reg      <= flags_next;
        end
    end

endmodule

// ----- hdl/tnr_back.sv -----
module tnr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  tnr_pkg::desc_t     q_head,
    input  tnr_pkg::code_tbl_t codes,
    input  logic               out_stall,
    output logic               pop,
    output logic               cur_valid,
    output logic               out_valid,
    output tnr_pkg::res_t      out_res,
    output logic               out_last
);
    import tnr_pkg::*;

    logic  cur_valid_reg, cur_valid_next;
    desc_t cur_reg, cur_next;
    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg, out_res_next;
    logic  out_last_reg, out_last_next;

    logic [MIDX_W-1:0] sel_idx;
    logic [MASK_W-1:0] sel_bit;
    res_t              gen_res;
    logic              gen_last;
    logic              load_out;
    logic              fire;
    logic              done;

    assign cur_valid = cur_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        // lowest pending bit of a start sweep
        sel_idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (cur_reg.mask[i])
            begin
                sel_idx = MIDX_W'(i);
            end
        end
        sel_bit = MASK_W'(1) << sel_idx;

        if (cur_reg.start)
        begin
            gen_res  = mk_res(KIND_SEND, 8'h00, sel_idx[0] ? VERB_DO : VERB_WILL,
                              codes[sel_idx[MIDX_W-1:1]], EV_LOCAL_EN);
            gen_last = ((cur_reg.mask & ~sel_bit) == '0);
        end
        else
        begin
            gen_res  = cur_reg.r0;
            gen_last = !cur_reg.two;
        end

        load_out = !out_valid_reg || !out_stall;
        fire     = load_out && cur_valid_reg;
        done     = fire && gen_last;
        pop      = q_valid && (!cur_valid_reg || done);

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (pop)
        begin
            cur_next       = q_head;
            cur_valid_next = 1'b1;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (fire)
        begin
            cur_next.mask = cur_reg.mask & ~sel_bit;
            cur_next.r0   = cur_reg.r1;
            cur_next.two  = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        out_last_next  = out_last_reg;
        if (load_out)
        begin
            out_valid_next = cur_valid_reg;
            out_res_next   = gen_res;
            out_last_next  = gen_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- hdl/telnet_receive_negotiator.sv -----
// Telnet receive parser and option negotiator. Received bytes (op 0) and start
// requests (op 1) come in on the in_valid/in_stall channel; result words leave on
// out_valid/out_stall with kind, byte_value, verb, option_code, event_code and a
// last flag on the final word of each input word. The front end parses IAC
// sequences, looks options up in the four-entry table and updates the option
// flags in the cycle a word is accepted; it accepts one word per cycle while its
// two-deep job queue has room. The back end drains one job at a time and sends
// one result word per cycle while out_stall is low, through a registered output;
// a received byte produces up to two result words (or none) and a start request
// one per supported side, up to eight. A result passes through the job queue,
// the back end's current-job register and the output register. The option table
// is written through cfg_write/cfg_index/cfg_data and must only change while the
// block is idle.
`include "assert_macros.svh"

module telnet_receive_negotiator #(
    parameter int NUM_OPTIONS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input words
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [7:0]                     rx_byte,
    // result words
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     kind,
    output logic [7:0]                     byte_value,
    output logic [1:0]                     verb,
    output logic [7:0]                     option_code,
    output logic [2:0]                     event_code,
    output logic                           last,
    // option table writes
    input  logic                           cfg_write,
    input  logic [tnr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tnr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tnr_pkg::*;

    // option table registers
    code_tbl_t code_reg, code_next;
    sup_tbl_t  sup_reg, sup_next;

    logic               in_accept;
    logic               push;
    desc_t              push_desc;
    logic               q_full;
    logic               q_valid;
    desc_t              q_head;
    logic               pop;
    logic               cur_valid;
    res_t               out_res;
    logic [ENTRY_W-1:0] cfg_entry;

    // back-pressure only from the job queue
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    // low index bit picks code or support, the rest the table entry
    assign cfg_entry = cfg_index[CFG_IDX_W-1:1];

    always_comb
    begin
        code_next = code_reg;
        sup_next  = sup_reg;
        if (cfg_write)
        begin
            if (cfg_index[0] == REG_SEL_SUPPORT)
            begin
                sup_next[cfg_entry] = cfg_data[1:0];
            end
            else
            begin
                code_next[cfg_entry] = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= '0;
            sup_reg  <= '0;
        end
        else
        begin
            code_reg <= code_next;
            sup_reg  <= sup_next;
        end
    end

    // parse, look up and update option flags
    tnr_front #(
        .NUM_OPTIONS (NUM_OPTIONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .op        (op),
        .rx_byte   (rx_byte),
        .codes     (code_reg),
        .sups      (sup_reg),
        .push      (push),
        .push_desc (push_desc)
    );

    // short job queue between the two halves
    tnr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    // expand jobs into result words
    tnr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .codes     (code_reg),
        .out_stall (out_stall),
        .pop       (pop),
        .cur_valid (cur_valid),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_last  (last)
    );

    assign kind        = out_res.kind;
    assign byte_value  = out_res.byte_value;
    assign verb        = out_res.verb;
    assign option_code = out_res.option_code;
    assign event_code  = out_res.event_code;

    // a queued job means the back end holds a job in the next cycle
    `ASSERT_NEXT(a_job_taken, q_valid, cur_valid, "queued job not picked up")
    // output only turns valid from a job that was in progress
    `ASSERT_IMPL(a_out_from_job, $rose(out_valid), $past(cur_valid), "result without a job")
    // words of one input word go out back to back
    `ASSERT_NEXT(a_no_gap, out_valid && !out_stall && !last, out_valid,
                 "gap inside a burst")
    // a full queue always has a job to offer
    `ASSERT_PROP(a_full_valid, !q_full || q_valid, "queue full but empty")

endmodule

// ----- tb/telnet_result_checker.sv -----
`timescale 1ns / 1ps

module telnet_result_checker #(
    parameter int NUM_OPTIONS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           op,
    input  logic [7:0]                     rx_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [2:0]                     kind,
    input  logic [7:0]                     byte_value,
    input  logic [1:0]                     verb,
    input  logic [7:0]                     option_code,
    input  logic [2:0]                     event_code,
    input  logic                           last,
    input  logic                           cfg_write,
    input  logic [tnr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tnr_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             results_checked,
    output int                             words_pending
);
    import tnr_pkg::*;

    typedef struct packed {
        res_t fields;
        logic last;
    } result_word_t;

    result_word_t expected_results [$];

    // mirror of the option table and the parser
    logic [7:0] code_table    [TABLE_SLOTS];
    logic [1:0] support_table [TABLE_SLOTS];
    logic [3:0] option_flags  [TABLE_SLOTS];
    phase_t     parse_phase;
    verb_t      held_verb;
    logic [7:0] sub_option;
    logic       sub_known;

    function automatic string describe(result_word_t w);
        return $sformatf("kind %0d byte %02h verb %0d option %0d event %0d last %0b",
                         w.fields.kind, w.fields.byte_value, w.fields.verb,
                         w.fields.option_code, w.fields.event_code, w.last);
    endfunction

    // lowest matching entry wins, -1 when none
    function automatic int find_entry(logic [7:0] opt);
        int i;
        for (i = 0; i < NUM_OPTIONS && i < TABLE_SLOTS; i++)
            if (code_table[i] == opt)
                return i;
        return -1;
    endfunction

    task automatic push_result(kind_t k, logic [7:0] b, verb_t v, logic [7:0] opt,
                               event_t ev);
        result_word_t w;
        w.fields.kind        = k;
        w.fields.byte_value  = b;
        w.fields.verb        = v;
        w.fields.option_code = opt;
        w.fields.event_code  = ev;
        w.last               = 1'b0;
        expected_results.insert(expected_results.size(), w);
    endtask

    task automatic answer_option(verb_t v, logic [7:0] opt);
        int         e;
        logic [1:0] sup;
        logic [3:0] f;
        e = find_entry(opt);
        if (e < 0)
        begin
            // unknown option: refuse requests, ignore refusals
            if (v == VERB_WILL)
                push_result(KIND_SEND, 8'h00, VERB_DONT, opt, EV_LOCAL_EN);
            else if (v == VERB_DO)
                push_result(KIND_SEND, 8'h00, VERB_WONT, opt, EV_LOCAL_EN);
            return;
        end
        sup = support_table[e];
        f   = option_flags[e];
        case (v)
            VERB_WILL:
            begin
                if (sup[SUP_REMOTE])
                begin
                    if (!f[FLAG_REN])
                    begin
                        f[FLAG_REN] = 1'b1;
                        if (!f[FLAG_RNEG])
                            push_result(KIND_SEND, 8'h00, VERB_DO, opt, EV_LOCAL_EN);
                        push_result(KIND_EVENT, 8'h00, VERB_WILL, opt, EV_REMOTE_EN);
                    end
                end
                else
                    push_result(KIND_SEND, 8'h00, VERB_DONT, opt, EV_LOCAL_EN);
            end
            VERB_DO:
            begin
                if (sup[SUP_LOCAL])
                begin
                    if (!f[FLAG_LEN])
                    begin
                        f[FLAG_LEN] = 1'b1;
                        if (!f[FLAG_LNEG])
                            push_result(KIND_SEND, 8'h00, VERB_WILL, opt, EV_LOCAL_EN);
                        push_result(KIND_EVENT, 8'h00, VERB_WILL, opt, EV_LOCAL_EN);
                    end
                end
                else
                    push_result(KIND_SEND, 8'h00, VERB_WONT, opt, EV_LOCAL_EN);
            end
            VERB_WONT:
            begin
                if (sup[SUP_REMOTE])
                begin
                    if (f[FLAG_REN])
                    begin
                        f[FLAG_REN] = 1'b0;
                        push_result(KIND_EVENT, 8'h00, VERB_WILL, opt, EV_REMOTE_DIS);
                    end
                    if (f[FLAG_RNEG])
                    begin
                        f[FLAG_RNEG] = 1'b0;
                        push_result(KIND_EVENT, 8'h00, VERB_WILL, opt, EV_REMOTE_REJ);
                    end
                end
            end
            default:
            begin
                if (sup[SUP_LOCAL])
                begin
                    if (f[FLAG_LEN])
                    begin
                        f[FLAG_LEN] = 1'b0;
                        push_result(KIND_EVENT, 8'h00, VERB_WILL, opt, EV_LOCAL_DIS);
                    end
                    if (f[FLAG_LNEG])
                    begin
                        f[FLAG_LNEG] = 1'b0;
                        push_result(KIND_EVENT, 8'h00, VERB_WILL, opt, EV_LOCAL_REJ);
                    end
                end
            end
        endcase
        option_flags[e] = f;
    endtask

    task automatic take_byte(logic [7:0] b);
        logic [7:0] d;
        case (parse_phase)
            PH_IDLE:
            begin
                if (b == B_IAC)
                    parse_phase = PH_IAC;
                else
                    push_result(KIND_DATA, b, VERB_WILL, 8'h00, EV_LOCAL_EN);
            end
            PH_IAC:
            begin
                if (b == B_IAC)
                begin
                    push_result(KIND_DATA, B_IAC, VERB_WILL, 8'h00, EV_LOCAL_EN);
                    parse_phase = PH_IDLE;
                end
                else if (b >= B_WILL && b <= B_DONT)
                begin
                    d           = b - B_WILL;
                    held_verb   = verb_t'(d[1:0]);
                    parse_phase = PH_VERB;
                end
                else if (b == B_SB)
                    parse_phase = PH_SBOPT;
                else
                begin
                    push_result(KIND_CMD, b, VERB_WILL, 8'h00, EV_LOCAL_EN);
                    parse_phase = PH_IDLE;
                end
            end
            PH_VERB:
            begin
                answer_option(held_verb, b);
                parse_phase = PH_IDLE;
            end
            PH_SBOPT:
            begin
                sub_option  = b;
                sub_known   = (find_entry(b) >= 0);
                parse_phase = PH_SUB;
            end
            PH_SUB:
            begin
                if (b == B_IAC)
                    parse_phase = PH_SUBIAC;
                else if (sub_known)
                    push_result(KIND_SUB, b, VERB_WILL, sub_option, EV_LOCAL_EN);
            end
            PH_SUBIAC:
            begin
                if (b == B_SE)
                begin
                    if (sub_known)
                        push_result(KIND_SUB_END, 8'h00, VERB_WILL, sub_option, EV_LOCAL_EN);
                    parse_phase = PH_IDLE;
                end
                else
                begin
                    if (sub_known)
                    begin
                        push_result(KIND_SUB, B_IAC, VERB_WILL, sub_option, EV_LOCAL_EN);
                        if (b != B_IAC)
                            push_result(KIND_SUB, b, VERB_WILL, sub_option, EV_LOCAL_EN);
                    end
                    parse_phase = PH_SUB;
                end
            end
            default: parse_phase = PH_IDLE;
        endcase
    endtask

    task automatic announce_all();
        int i;
        for (i = 0; i < NUM_OPTIONS && i < TABLE_SLOTS; i++)
        begin
            if (support_table[i][SUP_LOCAL])
            begin
                option_flags[i][FLAG_LNEG] = 1'b1;
                push_result(KIND_SEND, 8'h00, VERB_WILL, code_table[i], EV_LOCAL_EN);
            end
            if (support_table[i][SUP_REMOTE])
            begin
                option_flags[i][FLAG_RNEG] = 1'b1;
                push_result(KIND_SEND, 8'h00, VERB_DO, code_table[i], EV_LOCAL_EN);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int           before_cnt;
        result_word_t got;
        result_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                code_table[i]    = 8'h00;
                support_table[i] = 2'b00;
                option_flags[i]  = 4'h0;
            end
            parse_phase     = PH_IDLE;
            held_verb       = VERB_WILL;
            sub_option      = 8'h00;
            sub_known       = 1'b0;
            expected_results.delete();
            fail_count      = 0;
            results_checked = 0;
            words_pending   = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index[0] == REG_SEL_SUPPORT)
                    support_table[cfg_index[CFG_IDX_W-1:1]] = cfg_data[1:0];
                else
                    code_table[cfg_index[CFG_IDX_W-1:1]] = cfg_data;
            end

            if (out_valid && !out_stall)
            begin
                got.fields.kind        = kind_t'(kind);
                got.fields.byte_value  = byte_value;
                got.fields.verb        = verb_t'(verb);
                got.fields.option_code = option_code;
                got.fields.event_code  = event_t'(event_code);
                got.last               = last;
                results_checked++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result mismatch, expected no word, actual %s",
                             $time, describe(got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        $display("%0t: result mismatch, expected %s, actual %s",
                                 $time, describe(want), describe(got));
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                before_cnt = expected_results.size();
                if (op == OP_START)
                    announce_all();
                else
                    take_byte(rx_byte);
                // flag the final word caused by this input
                if (expected_results.size() > before_cnt)
                begin
                    want      = expected_results[expected_results.size() - 1];
                    want.last = 1'b1;
                    expected_results[expected_results.size() - 1] = want;
                end
            end

            words_pending = expected_results.size();
        end
    end

endmodule

// ----- tb/telnet_receive_negotiator_test.sv -----
`timescale 1ns / 1ps

module telnet_receive_negotiator_test;
    import tnr_pkg::*;

    localparam int   RESET_CYCLES    = 10;
    localparam int   QUIET_LIMIT     = 2000;   // cycles with no input, result or config transfer
    localparam int   SETTLE_CYCLES   = 20;     // settle time once no result words are pending
    localparam int   HOLD_OFF_CYCLES = 150;
    localparam int   IDLE_PERCENT    = 31;
    localparam logic REG_SEL_CODE    = ~REG_SEL_SUPPORT;

    // command bytes the package does not name
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;

    // option numbers of the opening table, plus one outside it
    localparam logic [7:0] OPT_ECHO  = 8'd1;
    localparam logic [7:0] OPT_SGA   = 8'd3;
    localparam logic [7:0] OPT_TTYPE = 8'd24;
    localparam logic [7:0] OPT_NAWS  = 8'd31;
    localparam logic [7:0] OPT_ALIEN = 8'd200;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  op        = OP_BYTE;
    logic [7:0]            rx_byte   = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [2:0]            kind;
    logic [7:0]            byte_value;
    logic [1:0]            verb;
    logic [7:0]            option_code;
    logic [2:0]            event_code;
    logic                  last;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int results_checked;
    int words_pending;

    int words_sent      = 0;
    int settings_loaded = 0;
    int quiet_cycles    = 0;

    // idling switches, cleared for the stretch with no gaps at all
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_off_due   = 1'b0;

    // copy of the current option table, used to aim random negotiations
    logic [7:0] table_codes   [TABLE_SLOTS];
    logic [1:0] table_support [TABLE_SLOTS];

    telnet_receive_negotiator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .byte_value  (byte_value),
        .verb        (verb),
        .option_code (option_code),
        .event_code  (event_code),
        .last        (last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    telnet_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .byte_value      (byte_value),
        .verb            (verb),
        .option_code     (option_code),
        .event_code      (event_code),
        .last            (last),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .results_checked (results_checked),
        .words_pending   (words_pending)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d result words still expected",
                     $time, QUIET_LIMIT, words_pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stall, plus one long hold-off that backs the
    // block up until it stalls its input
    initial
    begin : result_sink
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_due && held < HOLD_OFF_CYCLES)
            begin
                out_stall <= 1'b1;
                held++;
            end
            else if (receiver_idles)
                out_stall <= ($urandom_range(99) < IDLE_PERCENT);
            else
                out_stall <= 1'b0;
        end
    end

    // offer one word and hold it until the block takes it
    task automatic send_word(input logic o, input logic [7:0] b);
        while (sender_idles && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // IAC followed by one byte
    task automatic send_command(input logic [7:0] b);
        send_word(OP_BYTE, B_IAC);
        send_word(OP_BYTE, b);
    endtask

    task automatic send_option(input logic [7:0] verb_byte, input logic [7:0] opt);
        send_command(verb_byte);
        send_word(OP_BYTE, opt);
    endtask

    // IAC SB opt, a few payload bytes with escapes mixed in, IAC SE;
    // now and then the end is dropped so the parser stays inside
    task automatic send_subneg(input logic [7:0] opt);
        int         count;
        int         i;
        int         pick;
        logic [7:0] x;
        count = $urandom_range(4);
        send_command(B_SB);
        send_word(OP_BYTE, opt);
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                send_command(B_IAC);
            else if (pick == 1)
            begin
                x = 8'($urandom_range(254));
                if (x == B_SE)
                    x = 8'h00;
                send_command(x);
            end
            else
                send_word(OP_BYTE, 8'($urandom_range(254)));
        end
        if ($urandom_range(9) != 0)
            send_command(B_SE);
    endtask

    // mostly options from the table, sometimes anything
    function automatic logic [7:0] pick_option();
        if ($urandom_range(3) != 0)
            return table_codes[ENTRY_W'($urandom_range(TABLE_SLOTS - 1))];
        return 8'($urandom_range(255));
    endfunction

    // well-formed telnet sequences with random content, plus noise
    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        stop_at = words_sent + count;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                send_word(OP_BYTE, 8'($urandom_range(254)));
            else if (pick < 55)
                send_option(8'(B_WILL + $urandom_range(3)), pick_option());
            else if (pick < 70)
                send_subneg(pick_option());
            else if (pick < 77)
                send_word(OP_START, 8'($urandom_range(255)));
            else if (pick < 84)
                send_command(B_IAC);
            else if (pick < 92)
                send_command(8'($urandom_range(255)));
            else
                send_word(OP_BYTE, $urandom_range(1) ? B_IAC : 8'($urandom_range(255)));
        end
    endtask

    // let everything drain, then settle for words with no result
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all eight table registers, code then support per entry
    task automatic load_option_table(input logic [7:0] c0, input logic [7:0] c1,
                                     input logic [7:0] c2, input logic [7:0] c3,
                                     input logic [1:0] s0, input logic [1:0] s1,
                                     input logic [1:0] s2, input logic [1:0] s3);
        int i;
        table_codes[0]   = c0;
        table_codes[1]   = c1;
        table_codes[2]   = c2;
        table_codes[3]   = c3;
        table_support[0] = s0;
        table_support[1] = s1;
        table_support[2] = s2;
        table_support[3] = s3;
        for (i = 0; i < TABLE_SLOTS; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= {i[ENTRY_W-1:0], REG_SEL_CODE};
            cfg_data  <= table_codes[i];
            @(posedge clk);
            cfg_index <= {i[ENTRY_W-1:0], REG_SEL_SUPPORT};
            cfg_data  <= {6'd0, table_support[i]};
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        settings_loaded++;
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            table_codes[i]   = 8'h00;
            table_support[i] = 2'b00;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start with the reset table: nothing supported, so no words come back
        send_word(OP_START, 8'hFF);
        wait_until_idle();

        load_option_table(OPT_ECHO, OPT_SGA, OPT_TTYPE, OPT_NAWS, 2'd3, 2'd2, 2'd1, 2'd3);

        // announce, then the corner cases one by one
        send_word(OP_START, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_command(B_IAC);                // escaped 255 comes out as data
        send_command(B_SE);                 // SE with no subnegotiation open is a command
        send_option(B_DO, OPT_ECHO);        // already asked for: event only, no reply
        send_option(B_DONT, OPT_ECHO);      // enabled and still negotiating: disable and reject
        send_option(B_DONT, OPT_SGA);       // local side not supported: silent
        send_option(B_WILL, OPT_ALIEN);     // unknown option gets DONT
        send_option(B_WONT, OPT_ALIEN);     // refusal of an unknown option: silent
        // escaped IAC and IAC with a stray byte inside a known subnegotiation
        send_command(B_SB);
        send_word(OP_BYTE, OPT_SGA);
        send_command(B_IAC);
        send_command(8'h07);
        send_command(B_SE);
        // option byte after SB taken as is, even 255; unknown so nothing comes out
        send_command(B_SB);
        send_word(OP_BYTE, B_IAC);
        send_word(OP_BYTE, 8'h41);
        send_command(B_SE);

        // random traffic, opened by the long hold-off on the result side
        hold_off_due = 1'b1;
        random_traffic(75);
        wait_until_idle();

        // extreme codes, duplicate 255, one entry with nothing supported
        load_option_table(8'd255, 8'd0, 8'd255, 8'd128, 2'd3, 2'd3, 2'd0, 2'd1);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        random_traffic(40);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        random_traffic(35);
        wait_until_idle();

        // all entries the same code, the winning one supports neither side
        load_option_table(8'd5, 8'd5, 8'd5, 8'd5, 2'd0, 2'd3, 2'd3, 2'd3);
        random_traffic(60);
        wait_until_idle();

        // every side supported: a start gives eight words
        load_option_table(8'd0, 8'd255, 8'd17, 8'd42, 2'd3, 2'd3, 2'd3, 2'd3);
        random_traffic(60);
        wait_until_idle();

        $display("sent %0d input words across %0d option table settings, checked %0d result words",
                 words_sent, settings_loaded, results_checked);
        $display("covered data, escapes, commands, negotiation, subnegotiation and start sweeps");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
